// ----- hw/rtl/servo_bus_reply_frame_checker_defines.svh -----
// ---------------------------------------------------------------------------
// Servo bus reply frame checker assertion macros
// Shared assertion shorthands for the frame checker's checker module.
// ---------------------------------------------------------------------------
`ifndef SERVO_BUS_REPLY_FRAME_CHECKER_DEFINES_SVH
`define SERVO_BUS_REPLY_FRAME_CHECKER_DEFINES_SVH

// same-cycle implication, disabled while rst is high
`define SBRFC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while rst is high
`define SBRFC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/sbrfc_pkg.sv -----
// ---------------------------------------------------------------------------
// sbrfc_pkg
// Types, codes and constants shared by the servo reply frame checker.
// ---------------------------------------------------------------------------
package sbrfc_pkg;

   localparam int RX_STORE_BYTES_DEF = 16;
   localparam int FRAME_STORE_BYTES  = 10;   // highest byte ever checked is 9
   localparam int STORE_IDX_W        = $clog2(FRAME_STORE_BYTES);

   localparam logic [7:0] HEADER_RESET = 8'h55;

   localparam logic [2:0] LEN_ONE_BYTE  = 3'd4;
   localparam logic [2:0] LEN_ONE_WORD  = 3'd5;
   localparam logic [2:0] LEN_TWO_WORDS = 3'd7;
   localparam logic [3:0] MIN_FRAME_BYTES = 4'd5;

   localparam logic [2:0] STATUS_OK        = 3'd0;
   localparam logic [2:0] STATUS_HEADER    = 3'd1;
   localparam logic [2:0] STATUS_ID        = 3'd2;
   localparam logic [2:0] STATUS_LENGTH    = 3'd3;
   localparam logic [2:0] STATUS_COMMAND   = 3'd4;
   localparam logic [2:0] STATUS_CHECKSUM  = 3'd5;
   localparam logic [2:0] STATUS_TRUNCATED = 3'd6;

   localparam int          CSR_ADDR_W = 3;
   localparam int          CSR_DATA_W = 32;
   localparam logic        CSR_IDX_HEADER = 1'b0;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       end_of_frame;
      logic [7:0] expected_id;
      logic       check_id;
      logic [7:0] expected_cmd;
      logic [2:0] expected_len;
   } item_type;

   typedef struct packed {
      logic [2:0]         status;
      logic signed [15:0] value_first;
      logic signed [15:0] value_second;
   } result_type;

endpackage

// ----- hw/rtl/sbrfc_if.sv -----
// ---------------------------------------------------------------------------
// sbrfc channel interfaces
// Valid/ready channels for received bytes and frame results.
// ---------------------------------------------------------------------------
interface sbrfc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       end_of_frame;
   logic [7:0] expected_id;
   logic       check_id;
   logic [7:0] expected_cmd;
   logic [2:0] expected_len;

   modport source (output valid, rx_byte, end_of_frame, expected_id, check_id,
                   expected_cmd, expected_len, input ready);
   modport sink   (input valid, rx_byte, end_of_frame, expected_id, check_id,
                   expected_cmd, expected_len, output ready);
endinterface

interface sbrfc_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         status;
   logic signed [15:0] value_first;
   logic signed [15:0] value_second;

   modport source (output valid, status, value_first, value_second, input ready);
   modport sink   (input valid, status, value_first, value_second, output ready);
endinterface

// ----- hw/rtl/sbrfc_csr.sv -----
// ---------------------------------------------------------------------------
// sbrfc_csr
// APB-style register port holding the header byte.
// ---------------------------------------------------------------------------
module sbrfc_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [sbrfc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [sbrfc_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [sbrfc_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                             csr_pready,
   output logic [7:0]                       header_byte
);
   import sbrfc_pkg::*;

   logic [7:0] header_ff;
   logic [7:0] header_in;
   logic       hit;

   assign hit        = (csr_paddr[CSR_ADDR_W-1] == CSR_IDX_HEADER);
   assign csr_pready = 1'b1;

   always_comb begin
      header_in = header_ff;
      if (csr_psel && csr_penable && csr_pwrite && hit) begin
         header_in = csr_pwdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff <= HEADER_RESET;
      end else begin
         header_ff <= header_in;
      end
   end

   assign csr_prdata  = hit ? {{(CSR_DATA_W-8){1'b0}}, header_ff} : '0;
   assign header_byte = header_ff;

endmodule

// ----- hw/rtl/sbrfc_core.sv -----
// ---------------------------------------------------------------------------
// sbrfc_core
// Input register, frame byte store, running sum and end-of-frame checks.
// ---------------------------------------------------------------------------
module sbrfc_core #(
   parameter int RX_STORE_BYTES = sbrfc_pkg::RX_STORE_BYTES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [7:0]             header_byte,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  sbrfc_pkg::item_type    in_item,
   output logic                   out_valid,
   input  logic                   out_ready,
   output sbrfc_pkg::result_type  out_result
);
   import sbrfc_pkg::*;

   localparam int POS_W = $clog2(RX_STORE_BYTES + 1);

   item_type   item_ff;
   logic       item_vld_ff, item_vld_in;
   logic [POS_W-1:0] pos_ff, pos_in, pos_next;
   logic [7:0] sum_ff, sum_in, sum_next;
   logic [7:0] store_ff [FRAME_STORE_BYTES];
   logic [7:0] view     [FRAME_STORE_BYTES];
   result_type res_ff, res_in, res_calc;
   logic       res_vld_ff, res_vld_in;

   logic       advance, can_store, in_sum;
   logic [POS_W-1:0] elen_p1;
   logic [3:0] need;
   logic [3:0] chk_idx;
   logic [7:0] chk_byte;
   logic [7:0] b5, b6, b7, b8;

   // an item with no result never waits on the output side
   assign advance  = item_vld_ff && (!item_ff.end_of_frame || !res_vld_ff || out_ready);
   assign in_ready = !item_vld_ff || advance;

   assign can_store = pos_ff < POS_W'(RX_STORE_BYTES);
   assign pos_next  = can_store ? pos_ff + POS_W'(1) : pos_ff;
   assign elen_p1   = POS_W'(item_ff.expected_len) + POS_W'(1);
   assign in_sum    = can_store && (pos_ff >= POS_W'(2)) && (pos_ff <= elen_p1);
   assign sum_next  = in_sum ? sum_ff + item_ff.rx_byte : sum_ff;

   // store as it will look once this byte is written
   always_comb begin
      for (int k = 0; k < FRAME_STORE_BYTES; k++) begin
         view[k] = (can_store && pos_ff == POS_W'(k)) ? item_ff.rx_byte : store_ff[k];
      end
   end

   assign need = (item_ff.expected_len >= 3'd3) ? 4'(item_ff.expected_len) + 4'd3
                                                 : MIN_FRAME_BYTES;
   assign chk_idx  = 4'(item_ff.expected_len) + 4'd2;
   assign chk_byte = view[chk_idx];

   // drop stale bytes of an earlier frame
   assign b5 = (pos_next > POS_W'(5)) ? view[5] : 8'h00;
   assign b6 = (pos_next > POS_W'(6)) ? view[6] : 8'h00;
   assign b7 = (pos_next > POS_W'(7)) ? view[7] : 8'h00;
   assign b8 = (pos_next > POS_W'(8)) ? view[8] : 8'h00;

   always_comb begin
      res_calc = '0;
      if (pos_next < POS_W'(need)) begin
         res_calc.status = STATUS_TRUNCATED;
      end else if (view[0] != header_byte || view[1] != header_byte) begin
         res_calc.status = STATUS_HEADER;
      end else if (item_ff.check_id && view[2] != item_ff.expected_id) begin
         res_calc.status = STATUS_ID;
      end else if (view[3] != {5'd0, item_ff.expected_len}) begin
         res_calc.status = STATUS_LENGTH;
      end else if (view[4] != item_ff.expected_cmd) begin
         res_calc.status = STATUS_COMMAND;
      end else if (~sum_next != chk_byte) begin
         res_calc.status = STATUS_CHECKSUM;
      end else begin
         res_calc.status = STATUS_OK;
         if (item_ff.expected_len == LEN_TWO_WORDS) begin
            res_calc.value_first  = {b6, b5};
            res_calc.value_second = {b8, b7};
         end else if (item_ff.expected_len >= LEN_ONE_WORD) begin
            res_calc.value_first  = {b6, b5};
         end else begin
            res_calc.value_first  = {8'h00, b5};
         end
      end
   end

   always_comb begin
      item_vld_in = item_vld_ff;
      if (in_ready) begin
         item_vld_in = in_valid;
      end
      pos_in = pos_ff;
      sum_in = sum_ff;
      if (advance) begin
         pos_in = item_ff.end_of_frame ? '0 : pos_next;
         sum_in = item_ff.end_of_frame ? 8'h00 : sum_next;
      end
      res_vld_in = res_vld_ff && !out_ready;
      res_in     = res_ff;
      if (advance && item_ff.end_of_frame) begin
         res_vld_in = 1'b1;
         res_in     = res_calc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_vld_ff <= 1'b0;
         pos_ff      <= '0;
         sum_ff      <= 8'h00;
         res_vld_ff  <= 1'b0;
      end else begin
         item_vld_ff <= item_vld_in;
         pos_ff      <= pos_in;
         sum_ff      <= sum_in;
         res_vld_ff  <= res_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         item_ff <= in_item;
      end
      res_ff <= res_in;
      if (advance) begin
         for (int k = 0; k < FRAME_STORE_BYTES; k++) begin
            store_ff[k] <= view[k];
         end
      end
   end

   assign out_valid  = res_vld_ff;
   assign out_result = res_ff;

endmodule

// ----- hw/rtl/servo_bus_reply_frame_checker.sv -----
// A closing byte passes the input register; its frame result lands in the result register.
// Throughput: one byte per cycle unless a closing byte waits; the two registers set this.
// A closing byte waits in the input register only while a prior result is unclaimed.
// Reset clears the byte count, running sum and valid flags; header byte returns to 0x55.
// The frame byte store is not cleared; bytes are masked by the byte count instead.
// ---------------------------------------------------------------------------
// servo_bus_reply_frame_checker
// Checks servo reply frames received one byte at a time and reports status.
// ---------------------------------------------------------------------------
module servo_bus_reply_frame_checker #(
   parameter int RX_STORE_BYTES = sbrfc_pkg::RX_STORE_BYTES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   sbrfc_req_if.sink                        req,
   sbrfc_rsp_if.source                      rsp,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [sbrfc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [sbrfc_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [sbrfc_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                             csr_pready
);
   import sbrfc_pkg::*;

   logic [7:0] header_byte;
   item_type   item;
   result_type result;

   assign item.rx_byte      = req.rx_byte;
   assign item.end_of_frame = req.end_of_frame;
   assign item.expected_id  = req.expected_id;
   assign item.check_id     = req.check_id;
   assign item.expected_cmd = req.expected_cmd;
   assign item.expected_len = req.expected_len;

   sbrfc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .header_byte (header_byte)
   );

   sbrfc_core #(
      .RX_STORE_BYTES (RX_STORE_BYTES)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .header_byte (header_byte),
      .in_valid    (req.valid),
      .in_ready    (req.ready),
      .in_item     (item),
      .out_valid   (rsp.valid),
      .out_ready   (rsp.ready),
      .out_result  (result)
   );

   assign rsp.status       = result.status;
   assign rsp.value_first  = result.value_first;
   assign rsp.value_second = result.value_second;

endmodule

// ----- hw/rtl/sbrfc_checker.sv -----
// ---------------------------------------------------------------------------
// sbrfc_checker
// Port-level checks on the frame checker's result channel and register port.
// ---------------------------------------------------------------------------
`include "servo_bus_reply_frame_checker_defines.svh"

module sbrfc_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [2:0]         rsp_status,
   input logic signed [15:0] rsp_value_first,
   input logic signed [15:0] rsp_value_second,
   input logic               csr_pready
);
   import sbrfc_pkg::*;

   // hold a stalled result word
   `SBRFC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_value_first) && $stable(rsp_value_second), "stalled result word changed")
   `SBRFC_ASSERT_NOW(a_status_range, clock, reset, rsp_valid, rsp_status <= STATUS_TRUNCATED, "status code out of range")
   `SBRFC_ASSERT_NOW(a_err_zero, clock, reset, rsp_valid && rsp_status != STATUS_OK, rsp_value_first == 16'sd0 && rsp_value_second == 16'sd0, "error result carries nonzero values")
   `SBRFC_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_valid, "result valid right after reset")
   `SBRFC_ASSERT_NOW(a_pready, clock, reset, 1'b1, csr_pready, "register port not ready")

endmodule

bind servo_bus_reply_frame_checker sbrfc_checker u_sbrfc_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp.valid),
   .rsp_ready        (rsp.ready),
   .rsp_status       (rsp.status),
   .rsp_value_first  (rsp.value_first),
   .rsp_value_second (rsp.value_second),
   .csr_pready       (csr_pready)
);

// ----- tb/sv/tb_servo_bus_reply_frame_checker.sv -----
// ---------------------------------------------------------------------------
// Servo bus reply frame checker testbench
// Streams reply frames byte by byte: good frames of every length, each kind
// of broken frame, short and overlong frames, and random noise, all under
// several header settings. A local model predicts each frame result, and a
// scoreboard compares it with what the block returns, field by field.
// ---------------------------------------------------------------------------
module tb_servo_bus_reply_frame_checker;
   timeunit 1ns;
   timeprecision 1ps;

   import sbrfc_pkg::*;

   localparam int STORE_LIMIT    = RX_STORE_BYTES_DEF;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 8;
   localparam int PHASE_BYTES    = 275;
   localparam logic [CSR_ADDR_W-1:0] HEADER_ADDR = {CSR_IDX_HEADER, 2'b00};

   typedef enum {
      FRAME_GOOD, FRAME_BROADCAST, FRAME_BAD_HEADER, FRAME_BAD_ID, FRAME_BAD_LENGTH,
      FRAME_BAD_COMMAND, FRAME_BAD_SUM, FRAME_SHORT, FRAME_LONG, FRAME_NOISE
   } frame_kind_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   sbrfc_req_if req_ch ();
   sbrfc_rsp_if rsp_ch ();

   // frame model state
   logic [7:0] header_setting;
   logic [7:0] held_bytes [STORE_LIMIT];
   int         byte_count;
   logic [7:0] running_sum;
   result_type replies_due [$];

   bit calm;
   int errors;
   int words_sent;
   int frames_sent;
   int replies_checked;
   int header_writes;
   int stall_cycles;
   int status_hits [8];

   servo_bus_reply_frame_checker i_dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic void check_field(string what, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, what, want, got);
         errors++;
      end
   endfunction

   function automatic logic [7:0] byte_at(int pos);
      return (pos < byte_count && pos < STORE_LIMIT) ? held_bytes[pos] : 8'h00;
   endfunction

   function automatic logic [15:0] word_at(int pos);
      return {byte_at(pos + 1), byte_at(pos)};
   endfunction

   // Fold one accepted byte into the frame; on the closing byte queue the result.
   function automatic void absorb_byte(item_type w);
      result_type r;
      int         n;
      int         need;
      n = w.expected_len;
      if (byte_count < STORE_LIMIT) begin
         if (byte_count >= 2 && byte_count <= n + 1)
            running_sum = running_sum + w.rx_byte;
         held_bytes[byte_count] = w.rx_byte;
         byte_count++;
      end
      if (!w.end_of_frame)
         return;
      r = '0;
      need = (n + 3 > MIN_FRAME_BYTES) ? n + 3 : MIN_FRAME_BYTES;
      if (byte_count < need)
         r.status = STATUS_TRUNCATED;
      else if (byte_at(0) != header_setting || byte_at(1) != header_setting)
         r.status = STATUS_HEADER;
      else if (w.check_id && byte_at(2) != w.expected_id)
         r.status = STATUS_ID;
      else if (byte_at(3) != 8'(n))
         r.status = STATUS_LENGTH;
      else if (byte_at(4) != w.expected_cmd)
         r.status = STATUS_COMMAND;
      else if (~running_sum != byte_at(n + 2))
         r.status = STATUS_CHECKSUM;
      else begin
         r.status = STATUS_OK;
         if (w.expected_len == LEN_TWO_WORDS) begin
            r.value_first  = word_at(5);
            r.value_second = word_at(7);
         end else if (w.expected_len >= LEN_ONE_WORD) begin
            r.value_first = word_at(5);
         end else begin
            r.value_first = {8'h00, byte_at(5)};
         end
      end
      replies_due.push_back(r);
      status_hits[r.status]++;
      byte_count  = 0;
      running_sum = 8'h00;
   endfunction

   task automatic send_word(item_type w);
      if (!calm && $urandom_range(99) < 28)
         @(negedge clock) req_ch.valid <= 1'b0;
      @(negedge clock);
      req_ch.valid        <= 1'b1;
      req_ch.rx_byte      <= w.rx_byte;
      req_ch.end_of_frame <= w.end_of_frame;
      req_ch.expected_id  <= w.expected_id;
      req_ch.check_id     <= w.check_id;
      req_ch.expected_cmd <= w.expected_cmd;
      req_ch.expected_len <= w.expected_len;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      absorb_byte(w);
      words_sent++;
   endtask

   // Drop valid, wait out every pending result, then let the pipeline settle.
   task automatic drain_results();
      @(negedge clock) req_ch.valid <= 1'b0;
      while (replies_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_read(output logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= HEADER_ADDR;
      @(negedge clock) csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      data = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic program_header(logic [7:0] value);
      logic [CSR_DATA_W-1:0] readback;
      drain_results();
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= HEADER_ADDR;
      csr_pwdata  <= CSR_DATA_W'(value);
      @(negedge clock) csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      header_setting = value;
      header_writes++;
      csr_read(readback);
      check_field("header readback", 16'(value), readback[15:0]);
   endtask

   // Build a frame of the given kind, then stream it with the expected fields held.
   // pad < 0 fills id, command and parameters at random, else with pad.
   task automatic send_frame(frame_kind_type kind, int len_code, bit wobble, int pad);
      logic [7:0] octets [$];
      logic [7:0] chk_sum;
      logic [7:0] want_id;
      logic [7:0] want_cmd;
      bit         id_on;
      int         total;
      item_type   w;
      total = (len_code + 3 > MIN_FRAME_BYTES) ? len_code + 3 : MIN_FRAME_BYTES;
      for (int i = 0; i < total; i++)
         octets.push_back((pad < 0 || i < 2) ? 8'($urandom_range(255)) : 8'(pad));
      octets[0] = header_setting;
      octets[1] = header_setting;
      // length one puts the checksum on the length byte itself
      if (len_code == 1)
         octets[2] = 8'hFE;
      octets[3] = 8'(len_code);
      chk_sum = 8'h00;
      for (int i = 2; i <= len_code + 1; i++)
         chk_sum = chk_sum + octets[i];
      octets[len_code + 2] = ~chk_sum;
      want_id  = octets[2];
      want_cmd = octets[4];
      id_on    = 1'($urandom_range(1));
      case (kind)
         FRAME_BROADCAST: begin
            id_on   = 1'b0;
            want_id = ~want_id;
         end
         FRAME_BAD_HEADER:  octets[$urandom_range(1)] ^= 8'($urandom_range(1, 255));
         FRAME_BAD_ID: begin
            id_on   = 1'b1;
            want_id ^= 8'($urandom_range(1, 255));
         end
         FRAME_BAD_LENGTH:  octets[3] ^= 8'($urandom_range(1, 255));
         FRAME_BAD_COMMAND: want_cmd ^= 8'($urandom_range(1, 255));
         FRAME_BAD_SUM:     octets[len_code + 2] ^= 8'($urandom_range(1, 255));
         FRAME_SHORT:       repeat ($urandom_range(1, total - 1)) void'(octets.pop_back());
         FRAME_LONG:        repeat ($urandom_range(1, 12)) octets.push_back(8'($urandom_range(255)));
         FRAME_NOISE: begin
            octets.delete();
            repeat ($urandom_range(1, 18)) octets.push_back(8'($urandom_range(255)));
            want_id  = 8'($urandom_range(255));
            want_cmd = 8'($urandom_range(255));
            wobble   = 1'b1;
         end
         default: ;
      endcase
      foreach (octets[i]) begin
         w.rx_byte      = octets[i];
         w.end_of_frame = (i == octets.size() - 1);
         w.expected_id  = want_id;
         w.check_id     = id_on;
         w.expected_cmd = want_cmd;
         w.expected_len = wobble ? 3'($urandom_range(7)) : 3'(len_code);
         send_word(w);
      end
      frames_sent++;
   endtask

   task automatic test_header_reset();
      logic [CSR_DATA_W-1:0] value;
      csr_read(value);
      check_field("header after reset", 16'(HEADER_RESET), value[15:0]);
   endtask

   task automatic test_every_length();
      for (int n = 0; n < 8; n++)
         send_frame(FRAME_GOOD, n, 1'b0, -1);
      send_frame(FRAME_GOOD, LEN_TWO_WORDS, 1'b0, 8'h00);
      send_frame(FRAME_GOOD, LEN_TWO_WORDS, 1'b0, 8'hFF);
      send_frame(FRAME_GOOD, LEN_ONE_BYTE, 1'b0, 8'hFF);
   endtask

   task automatic test_error_codes();
      send_frame(FRAME_BAD_HEADER, LEN_ONE_BYTE, 1'b0, -1);
      send_frame(FRAME_BAD_ID, LEN_ONE_WORD, 1'b0, -1);
      send_frame(FRAME_BAD_LENGTH, LEN_TWO_WORDS, 1'b0, -1);
      send_frame(FRAME_BAD_COMMAND, 6, 1'b0, -1);
      send_frame(FRAME_BAD_SUM, LEN_TWO_WORDS, 1'b0, -1);
      send_frame(FRAME_SHORT, LEN_TWO_WORDS, 1'b0, -1);
      send_frame(FRAME_SHORT, LEN_ONE_BYTE, 1'b0, -1);
   endtask

   task automatic test_odd_frames();
      item_type w;
      send_frame(FRAME_BROADCAST, LEN_ONE_WORD, 1'b0, -1);
      send_frame(FRAME_LONG, LEN_TWO_WORDS, 1'b0, -1);
      send_frame(FRAME_GOOD, LEN_TWO_WORDS, 1'b1, -1);
      // a lone closing byte is the shortest frame there is
      w = '{rx_byte: header_setting, end_of_frame: 1'b1, expected_id: 8'hFF, check_id: 1'b1,
            expected_cmd: 8'hFF, expected_len: 3'd7};
      send_word(w);
      frames_sent++;
   endtask

   task automatic test_header_extremes();
      program_header(8'h00);
      send_frame(FRAME_GOOD, LEN_ONE_WORD, 1'b0, -1);
      send_frame(FRAME_BAD_HEADER, LEN_ONE_BYTE, 1'b0, -1);
      program_header(8'hFF);
      send_frame(FRAME_GOOD, LEN_TWO_WORDS, 1'b0, -1);
      send_frame(FRAME_BAD_HEADER, LEN_ONE_WORD, 1'b0, -1);
   endtask

   task automatic test_random_traffic();
      frame_kind_type mix [20] = '{
         FRAME_GOOD, FRAME_GOOD, FRAME_GOOD, FRAME_GOOD, FRAME_GOOD, FRAME_GOOD,
         FRAME_GOOD, FRAME_BROADCAST, FRAME_BROADCAST, FRAME_BAD_HEADER, FRAME_BAD_ID,
         FRAME_BAD_LENGTH, FRAME_BAD_COMMAND, FRAME_BAD_SUM, FRAME_BAD_SUM, FRAME_SHORT,
         FRAME_LONG, FRAME_NOISE, FRAME_NOISE, FRAME_GOOD};
      int target;
      int n;
      for (int ph = 0; ph < 4; ph++) begin
         program_header((ph == 3) ? HEADER_RESET : 8'($urandom_range(255)));
         calm   = (ph == 2);
         target = words_sent + PHASE_BYTES;
         while (words_sent < target) begin
            n = ($urandom_range(9) == 0) ? $urandom_range(3) : $urandom_range(4, 7);
            send_frame(mix[$urandom_range(19)], n, $urandom_range(19) == 0, -1);
         end
      end
      calm = 1'b0;
   endtask

   always @(negedge clock)
      rsp_ch.ready <= calm || ($urandom_range(99) >= 22);

   always @(posedge clock) begin
      result_type due;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (replies_due.size() == 0) begin
            $display("%0t ns: result with nothing expected, status %0d", $time, rsp_ch.status);
            errors++;
         end else begin
            due = replies_due.pop_front();
            check_field("status", 16'(due.status), 16'(rsp_ch.status));
            check_field("value_first", due.value_first, rsp_ch.value_first);
            check_field("value_second", due.value_second, rsp_ch.value_second);
            replies_checked++;
         end
      end
   end

   // Abort when nothing moves on any port for too long.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || csr_psel)
         stall_cycles <= 0;
      else if (stall_cycles == WATCHDOG_LIMIT) begin
         $display("%0t ns: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("[FAIL] regression broken");
         $finish;
      end else
         stall_cycles <= stall_cycles + 1;
   end

   initial begin
      int kinds;
      reset               = 1'b1;
      req_ch.valid        = 1'b0;
      req_ch.rx_byte      = 8'h00;
      req_ch.end_of_frame = 1'b0;
      req_ch.expected_id  = 8'h00;
      req_ch.check_id     = 1'b0;
      req_ch.expected_cmd = 8'h00;
      req_ch.expected_len = 3'd0;
      rsp_ch.ready        = 1'b0;
      csr_psel            = 1'b0;
      csr_penable         = 1'b0;
      csr_pwrite          = 1'b0;
      csr_paddr           = '0;
      csr_pwdata          = '0;
      header_setting      = HEADER_RESET;
      byte_count          = 0;
      running_sum         = 8'h00;
      repeat (9) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      test_header_reset();
      test_every_length();
      test_error_codes();
      test_odd_frames();
      test_header_extremes();
      test_random_traffic();
      drain_results();

      kinds = 0;
      foreach (status_hits[i])
         if (status_hits[i] != 0)
            kinds++;
      $display("Covered %0d frames in %0d bytes under %0d header writes.",
               frames_sent, words_sent, header_writes);
      $display("Checked %0d frame results spanning %0d distinct status codes.",
               replies_checked, kinds);
      if (errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
